// File: sv/fpa_pkg.sv
// Shared types and constants of the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GE      = 4'd4,
        OP_LE      = 4'd5,
        OP_EQ      = 4'd6,
        OP_NE      = 4'd7,
        OP_GT      = 4'd8,
        OP_LT      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_MUL    = 2'd1,
        CLS_DIV    = 2'd2
    } cls_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // One classified word as it waits between front and back.
    typedef struct packed {
        op_t                op;
        cls_t               cls;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        mag_a;
        logic [31:0]        mag_b;
        logic               neg;
        logic               dz;
    } item_t;

endpackage

// File: sv/fixed_point_alu.sv
// Top level of the signed fixed-point ALU.
`timescale 1ns / 1ps
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
// Input stream (s_*): one word per operation, holding the opcode and two raw
// operands. Output stream (m_*): one word per input word, in the same order,
// holding the raw result, the compare flag and the status code.
// Flow: the front decodes each word, takes operand magnitudes and pushes it
// into a four-entry queue; the back pulls from the queue into a fixed-length
// pipeline: prep (compares, add/sub, shifts done; 32x32 multiply), 32+FRAC_BITS
// restoring-divide stages (one quotient bit each), round, sign/status.
// Every operation takes the same path through the pipeline, whose length is set
// by the divider depth.
// Throughput: one word per cycle while m_tready stays high.
// Stall: while the output word is not taken the whole back pipeline holds;
// the queue keeps accepting until it fills, then s_tready drops.
// Reset: synchronous, active low; clears the queue and all valid bits.
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [3:0] op, [35:4] operand_a, [67:36] operand_b, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] result_raw, [32] compare_true, [34:33] status
);
    import fpa_pkg::*;

    item_t       push_item;
    item_t       head_item;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  status;

    // Decode and classify the incoming word.
    fpa_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // Decouple accept from execution.
    fpa_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // Execute, round and flag.
    fpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (q_not_empty),
        .in_item    (head_item),
        .in_pop     (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res),
        .out_cmp    (cmp),
        .out_status (status)
    );

    // Pack the result word; pad bits stay zero.
    assign m_tdata = {5'b00000, status, cmp, res};

endmodule

// File: sv/fpa_front.sv
// Front end: accept input words, decode and classify them.
`timescale 1ns / 1ps
module fpa_front (
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [71:0]     s_tdata,
    input  logic            q_full,
    output logic            q_push,
    output fpa_pkg::item_t  q_item
);
    import fpa_pkg::*;

    logic signed [31:0] a;
    logic signed [31:0] b;
    op_t                op;

    assign op = op_t'(s_tdata[3:0]);
    assign a  = s_tdata[35:4];
    assign b  = s_tdata[67:36];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item       = '0;
        q_item.op    = op;
        q_item.a     = a;
        q_item.b     = b;
        q_item.mag_a = a[31] ? (32'd0 - a) : a;
        q_item.mag_b = b[31] ? (32'd0 - b) : b;
        q_item.neg   = a[31] ^ b[31];
        q_item.dz    = (b == 32'sd0);
        unique case (op)
            OP_MUL:  q_item.cls = CLS_MUL;
            OP_DIV:  q_item.cls = CLS_DIV;
            default: q_item.cls = CLS_SIMPLE;
        endcase
    end

endmodule

// File: sv/fpa_fifo.sv
// Short queue of classified words between front and back.
`timescale 1ns / 1ps
module fpa_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  fpa_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output fpa_pkg::item_t  head_item
);
    import fpa_pkg::*;

    item_t             mem_reg [0:Q_DEPTH-1];
    logic [Q_AW-1:0]   wptr_reg;
    logic [Q_AW-1:0]   rptr_reg;
    logic [Q_AW:0]     cnt_reg;
    logic [Q_AW:0]     cnt_next;

    assign full      = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_item = mem_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        priority if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= push_item;
    end

endmodule

// File: sv/fpa_back.sv
// Back end: execution pipeline with multiplier, restoring divider and rounding.
`timescale 1ns / 1ps
module fpa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  fpa_pkg::item_t  in_item,
    output logic            in_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [31:0]     out_res,
    output logic            out_cmp,
    output logic [1:0]      out_status
);
    import fpa_pkg::*;

    localparam int DW = 32 + FRAC_BITS;

    typedef struct packed {
        cls_t         cls;
        logic         neg;
        logic         dz;
        logic [31:0]  res;
        logic         cmp;
        logic         ovf;
        logic [63:0]  prod;
        logic [32:0]  rem;
        logic [DW-1:0] quo;
        logic [31:0]  den;
        logic [63:0]  mag;
    } stage_t;

    stage_t  st_reg  [0:DW];
    logic    vld_reg [0:DW];
    stage_t  rnd_reg;
    logic    rnd_vld_reg;
    stage_t  prep_next;
    stage_t  rnd_next;
    logic    en;

    logic [31:0] res_reg, res_next;
    logic        cmp_reg, cmp_next;
    logic [1:0]  status_reg, status_next;
    logic        out_vld_reg;

    assign en     = out_ready || !out_vld_reg;
    assign in_pop = in_valid && en;

    // Prep stage: simple ops finish here, the product is formed, divider is loaded.
    always_comb begin
        logic signed [32:0] ax;
        logic signed [32:0] bx;
        logic signed [32:0] s;
        logic               lt;
        logic               eq;
        logic [FRAC_BITS:0] hi;
        ax = {in_item.a[31], in_item.a};
        bx = {in_item.b[31], in_item.b};
        s  = '0;
        lt = (in_item.a < in_item.b);
        eq = (in_item.a == in_item.b);
        hi = in_item.a[31 -: FRAC_BITS+1];
        prep_next      = '0;
        prep_next.cls  = in_item.cls;
        prep_next.neg  = in_item.neg;
        prep_next.dz   = in_item.dz;
        prep_next.prod = 64'(in_item.mag_a) * 64'(in_item.mag_b);
        prep_next.quo  = DW'(in_item.mag_a) << FRAC_BITS;
        prep_next.den  = in_item.mag_b;
        unique case (in_item.op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                unique case (in_item.op)
                    OP_ADD:  s = ax + bx;
                    OP_SUB:  s = ax - bx;
                    OP_INC:  s = ax + 33'sd1;
                    default: s = ax - 33'sd1;
                endcase
                prep_next.res = s[31:0];
                prep_next.ovf = s[32] ^ s[31];
            end
            OP_GE: prep_next.cmp = !lt;
            OP_LE: prep_next.cmp = lt || eq;
            OP_EQ: prep_next.cmp = eq;
            OP_NE: prep_next.cmp = !eq;
            OP_GT: prep_next.cmp = !(lt || eq);
            OP_LT: prep_next.cmp = lt;
            OP_MIN: prep_next.res = (lt || eq) ? in_item.a : in_item.b;
            OP_MAX: prep_next.res = (!lt) ? in_item.a : in_item.b;
            OP_TOINT: prep_next.res = in_item.a >>> FRAC_BITS;
            OP_FROMINT: begin
                prep_next.res = in_item.a << FRAC_BITS;
                prep_next.ovf = !((hi == '0) || (hi == '1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) st_reg[0] <= prep_next;
    end

    // One quotient bit per stage.
    for (genvar k = 1; k <= DW; k++) begin : g_div
        logic [32:0] t;
        logic        ge;
        stage_t      nxt;
        always_comb begin
            t   = {st_reg[k-1].rem[31:0], st_reg[k-1].quo[DW-1]};
            ge  = (t >= {1'b0, st_reg[k-1].den});
            nxt = st_reg[k-1];
            nxt.rem = ge ? (t - {1'b0, st_reg[k-1].den}) : t;
            nxt.quo = {st_reg[k-1].quo[DW-2:0], ge};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) st_reg[k] <= nxt;
        end
    end

    // Round to nearest, halves away from zero, on magnitudes.
    always_comb begin
        logic rup;
        rup      = ({st_reg[DW].rem, 1'b0} >= {2'b00, st_reg[DW].den});
        rnd_next = st_reg[DW];
        unique case (st_reg[DW].cls)
            CLS_MUL: rnd_next.mag = (st_reg[DW].prod + (64'd1 << (FRAC_BITS-1)))
                                    >> FRAC_BITS;
            CLS_DIV: rnd_next.mag = 64'(st_reg[DW].quo) + 64'(rup);
            default: rnd_next.mag = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_vld_reg <= 1'b0;
        end else if (en) begin
            rnd_vld_reg <= vld_reg[DW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) rnd_reg <= rnd_next;
    end

    // Apply sign, detect wrap, pick the status.
    always_comb begin
        logic ovf;
        ovf = rnd_reg.neg ? ((rnd_reg.mag[63:32] != '0) ||
                             (rnd_reg.mag[31] && (rnd_reg.mag[30:0] != '0)))
                          : (rnd_reg.mag[63:31] != '0);
        res_next    = rnd_reg.res;
        cmp_next    = rnd_reg.cmp;
        status_next = rnd_reg.ovf ? ST_OVF : ST_OK;
        unique case (rnd_reg.cls)
            CLS_SIMPLE: ;
            CLS_MUL, CLS_DIV: begin
                cmp_next    = 1'b0;
                res_next    = rnd_reg.neg ? (32'd0 - rnd_reg.mag[31:0])
                                          : rnd_reg.mag[31:0];
                status_next = ovf ? ST_OVF : ST_OK;
                if (rnd_reg.cls == CLS_DIV && rnd_reg.dz) begin
                    res_next    = '0;
                    status_next = ST_DIVZ;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= rnd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg    <= res_next;
            cmp_reg    <= cmp_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_res    = res_reg;
    assign out_cmp    = cmp_reg;
    assign out_status = status_reg;

endmodule

// File: sv/fpa_checker.sv
// Port-level checks of the fixed-point ALU and their binding.
`timescale 1ns / 1ps
module fpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    // A stalled output word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Nothing comes out right after reset.
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Status code three is never produced.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:33] != 2'd3)
        else $error("invalid status code");

    // A true compare carries a zero result and ok status.
    a_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0 && m_tdata[34:33] == 2'd0)
        else $error("compare word with nonzero result or status");

    // Pad bits stay clear.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:35] == 5'd0)
        else $error("pad bits set");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
